@@ hw/rtl/pccc_pkg.sv @@
// ----------------------------------------------------------------------------
// pccc_pkg: shared types and constants of the coincidence counter
// Sizes of the channel map and the hit history, the layout of a channel
// row, the request structs between the sequencer and its stores, and the
// saturating helpers.
// ----------------------------------------------------------------------------
package pccc_pkg;

  // Geometry of the detector and the history
  localparam int unsigned NUM_SLOTS      = 20;
  localparam int unsigned CHANS_PER_SLOT = 13;
  localparam int unsigned HISTORY_DEPTH  = 8;
  localparam int unsigned TIME_BITS      = 48;

  // Fixed widths of the item fields
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned MISS_W   = 16;
  localparam int unsigned NEW_W    = 4;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned REG_IDX_W = 2;

  // Derived sizes
  localparam int unsigned NUM_CH  = NUM_SLOTS * CHANS_PER_SLOT;
  localparam int unsigned CH_W    = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int unsigned NUM_TS  = NUM_CH * HISTORY_DEPTH;
  localparam int unsigned TA_W    = (NUM_TS > 1) ? $clog2(NUM_TS) : 1;
  localparam int unsigned TIME_W  = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
  localparam int unsigned FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HEAD_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned HCNT_W  = FILL_W;
  localparam int unsigned ADD_W   = MISS_W + 1;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_BEFORE = 2'd0,
    REG_WINDOW_AFTER  = 2'd1
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OWN,
    S_RD_PAR,
    S_OWN_DATA,
    S_PAR_DATA,
    S_SCAN,
    S_DRAIN,
    S_WR_PAR,
    S_WR_OWN,
    S_FIN
  } seq_state_e;

  // Per-channel row: counters and history bookkeeping
  typedef struct packed {
    logic [TOTAL_W-1:0] coinc;
    logic [TOTAL_W-1:0] hits;
    logic [HEAD_W-1:0]  head;
    logic [FILL_W-1:0]  fill;
  } chan_row_t;

  typedef struct packed {
    logic          re;
    logic          we;
    logic [CH_W-1:0] addr;
  } row_req_t;

  typedef struct packed {
    logic          re;
    logic          we;
    logic [TA_W-1:0] addr;
  } time_req_t;

  typedef struct packed {
    logic clr;
    logic acc;
  } win_ctl_t;

  // Lower edge of a window: every time counts when the window reaches below zero
  typedef struct packed {
    logic              all;
    logic [TIME_W-1:0] lim;
  } thr_t;

  function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] a,
                                                 input logic [ADD_W-1:0]   b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W + 1)'(b);
    if (s[TOTAL_W]) begin
      return {TOTAL_W{1'b1}};
    end
    return s[TOTAL_W-1:0];
  endfunction

  function automatic logic [NEW_W-1:0] sat_new(input logic [HCNT_W-1:0] c);
    if (32'(c) > 32'(2 ** NEW_W - 1)) begin
      return {NEW_W{1'b1}};
    end
    return NEW_W'(c);
  endfunction

endpackage

@@ hw/rtl/pccc_row_store.sv @@
// ----------------------------------------------------------------------------
// pccc_row_store: per-channel counter and history bookkeeping memory
// One row per channel, one access per cycle, registered read data. After
// reset a sweep writes every row to zero before the store reports ready.
// ----------------------------------------------------------------------------
module pccc_row_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pccc_pkg::row_req_t  req_i,
  input  pccc_pkg::chan_row_t wdata_i,
  output pccc_pkg::chan_row_t rdata_o,
  output logic                busy_o
);
  import pccc_pkg::*;

  chan_row_t       mem [NUM_CH];
  chan_row_t       rdata_q;
  logic [CH_W-1:0] clr_cnt_q;
  logic            busy_q;

  // Sweep the rows once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else if (busy_q) begin
      if (clr_cnt_q == CH_W'(NUM_CH - 1)) begin
        busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Write the sweep or the sequencer's row, read with a registered port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

@@ hw/rtl/pccc_time_store.sv @@
// ----------------------------------------------------------------------------
// pccc_time_store: ring buffers of recent hit times
// HISTORY_DEPTH entries per channel in one memory, one access per cycle,
// registered read data with a flag that marks the cycle it arrives in.
// ----------------------------------------------------------------------------
module pccc_time_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pccc_pkg::time_req_t           req_i,
  input  logic [pccc_pkg::TIME_W-1:0]   wdata_i,
  output logic [pccc_pkg::TIME_W-1:0]   rdata_o,
  output logic                          rvalid_o
);
  import pccc_pkg::*;

  logic [TIME_W-1:0] mem [NUM_TS];
  logic [TIME_W-1:0] rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // Mark the cycle in which read data is fresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= req_i.re;
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

@@ hw/rtl/pccc_window_unit.sv @@
// ----------------------------------------------------------------------------
// pccc_window_unit: shared window compare and coincidence tally
// Takes one partner time a cycle, tests it against both window edges and
// adds the outcomes to two running counts.
// ----------------------------------------------------------------------------
module pccc_window_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pccc_pkg::win_ctl_t            ctl_i,
  input  logic [pccc_pkg::TIME_W-1:0]   time_i,
  input  pccc_pkg::thr_t                thr_before_i,
  input  pccc_pkg::thr_t                thr_after_i,
  output logic [pccc_pkg::HCNT_W-1:0]   own_cnt_o,
  output logic [pccc_pkg::HCNT_W-1:0]   par_cnt_o
);
  import pccc_pkg::*;

  logic [HCNT_W-1:0] own_q;
  logic [HCNT_W-1:0] par_q;
  logic              in_before;
  logic              in_after;

  // A partner time counts when it lies strictly after the lower edge
  assign in_before = thr_before_i.all || (time_i > thr_before_i.lim);
  assign in_after  = thr_after_i.all  || (time_i > thr_after_i.lim);

  // Clear at the start of an item, tally each fresh partner time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      par_q <= '0;
    end else if (ctl_i.clr) begin
      own_q <= '0;
      par_q <= '0;
    end else if (ctl_i.acc) begin
      own_q <= own_q + HCNT_W'(in_before);
      par_q <= par_q + HCNT_W'(in_after);
    end
  end

  assign own_cnt_o = own_q;
  assign par_cnt_o = par_q;

endmodule

@@ hw/rtl/paired_channel_coincidence_counter.sv @@
// ----------------------------------------------------------------------------
// paired_channel_coincidence_counter: coincidence counter for paired channels
// Counts hits and asymmetric-window coincidences between channel pairs.
// ----------------------------------------------------------------------------
// Hits arrive time-sorted, addressed by slot and channel; channels 2k and
// 2k+1 form a pair. The block handles one item at a time under a small
// sequencer. A hit with a partner reads its own row and its partner's row,
// lets the single window unit test one stored partner time per cycle as it
// streams out of the time memory, and then writes back the partner row, the
// own row and its time; with an empty partner history the scan is skipped.
// A hit on an unpaired channel reads and writes only its own row, a read
// command only reads it, and an item with a bad address goes straight to the
// result. A held result stretches the last step until it is taken. The result
// waits in an output register, so the next item is taken while it is held.
// After reset the counter memory is swept to zero (one row per channel) and
// no item is accepted until the sweep is done;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module paired_channel_coincidence_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [pccc_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pccc_pkg::WIN_W-1:0]        cfg_wdata_i,
  // Input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [pccc_pkg::SLOT_W-1:0]       slot_i,
  input  logic [pccc_pkg::CHAN_W-1:0]       chan_i,
  input  logic [pccc_pkg::STAMP_W-1:0]      hit_time_i,
  input  logic [pccc_pkg::MISS_W-1:0]       missed_triggers_i,
  // Result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pccc_pkg::NEW_W-1:0]        new_coinc_own_o,
  output logic [pccc_pkg::NEW_W-1:0]        new_coinc_partner_o,
  output logic [pccc_pkg::TOTAL_W-1:0]      hit_total_o,
  output logic [pccc_pkg::TOTAL_W-1:0]      coinc_total_o,
  output logic [pccc_pkg::STAMP_W-1:0]      run_span_o,
  output logic                              bad_address_o
);
  import pccc_pkg::*;

  seq_state_e state_q, state_d;

  // Configuration registers
  logic [WIN_W-1:0] win_before_q;
  logic [WIN_W-1:0] win_after_q;

  // Item registers
  logic              cmd_q;
  logic              bad_q;
  logic              has_par_q;
  logic [TIME_W-1:0] t_q;
  logic [MISS_W-1:0] miss_q;
  logic [CH_W-1:0]   idx_q;
  logic [CH_W-1:0]   pidx_q;
  logic [TA_W-1:0]   obase_q;
  logic [TA_W-1:0]   pbase_q;
  thr_t              thr_before_q;
  thr_t              thr_after_q;
  logic [FILL_W-1:0] scan_q;
  chan_row_t         own_row_q;
  chan_row_t         par_row_q;
  logic [TIME_W-1:0] latest_q;

  // Output register
  logic               out_valid_q;
  logic [NEW_W-1:0]   own_out_q;
  logic [NEW_W-1:0]   par_out_q;
  logic [TOTAL_W-1:0] hit_out_q;
  logic [TOTAL_W-1:0] coinc_out_q;
  logic [TIME_W-1:0]  span_out_q;
  logic               bad_out_q;

  // Decode of the incoming item
  logic              accept;
  logic              addr_ok;
  logic              has_par;
  logic [CH_W-1:0]   idx;
  logic [CH_W-1:0]   pidx;
  logic [TIME_W-1:0] t_in;
  logic [TIME_W:0]   diff_before;
  logic [TIME_W:0]   diff_after;

  // Sequencer controls
  logic      out_free;
  logic      out_load;
  row_req_t  row_req;
  time_req_t time_req;
  win_ctl_t  win_ctl;
  chan_row_t row_wdata;
  chan_row_t row_rdata;
  chan_row_t own_new;
  chan_row_t par_new;
  logic      row_busy;

  logic [TIME_W-1:0] time_rdata;
  logic              time_rvalid;
  logic [HCNT_W-1:0] own_cnt;
  logic [HCNT_W-1:0] par_cnt;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_before_q <= WIN_W'(125);
      win_after_q  <= WIN_W'(275);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_BEFORE: win_before_q <= cfg_wdata_i;
        REG_WINDOW_AFTER:  win_after_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Decode address and partner, take window edges at acceptance
  assign accept  = in_valid_i && !in_stall_o;
  assign addr_ok = (6'(slot_i) < 6'(NUM_SLOTS)) && (5'(chan_i) < 5'(CHANS_PER_SLOT));
  assign has_par = 5'(chan_i ^ 4'd1) < 5'(CHANS_PER_SLOT);
  assign idx     = CH_W'(CH_W'(slot_i) * CH_W'(CHANS_PER_SLOT)) + CH_W'(chan_i);
  assign pidx    = chan_i[0] ? (idx - 1'b1) : (idx + 1'b1);
  assign t_in    = hit_time_i[TIME_W-1:0];
  assign diff_before = {1'b0, t_in} - (TIME_W + 1)'(win_before_q);
  assign diff_after  = {1'b0, t_in} - (TIME_W + 1)'(win_after_q);

  // Updated rows
  always_comb begin
    par_new       = par_row_q;
    par_new.coinc = add_sat(par_row_q.coinc, ADD_W'(par_cnt));
    own_new       = own_row_q;
    own_new.hits  = add_sat(own_row_q.hits, ADD_W'(miss_q) + ADD_W'(1));
    own_new.coinc = add_sat(own_row_q.coinc, ADD_W'(own_cnt));
    own_new.head  = (32'(own_row_q.head) == HISTORY_DEPTH - 1) ? '0
                                                              : own_row_q.head + 1'b1;
    own_new.fill  = (32'(own_row_q.fill) < HISTORY_DEPTH) ? own_row_q.fill + 1'b1
                                                         : own_row_q.fill;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = addr_ok ? S_RD_OWN : S_FIN;
        end
      end
      S_RD_OWN:   state_d = (!cmd_q && has_par_q) ? S_RD_PAR : S_OWN_DATA;
      S_RD_PAR:   state_d = S_PAR_DATA;
      S_OWN_DATA: state_d = cmd_q ? S_FIN : S_WR_OWN;
      S_PAR_DATA: state_d = (row_rdata.fill == '0) ? S_WR_PAR : S_SCAN;
      S_SCAN: begin
        if (scan_q + 1'b1 == par_row_q.fill) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:    state_d = S_WR_PAR;
      S_WR_PAR:   state_d = S_WR_OWN;
      S_WR_OWN:   state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o    = 1'b1;
    out_load      = 1'b0;
    row_req       = '0;
    row_req.addr  = idx_q;
    row_wdata     = own_new;
    time_req      = '0;
    time_req.addr = pbase_q + TA_W'(scan_q);
    win_ctl.clr   = 1'b0;
    win_ctl.acc   = time_rvalid;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = row_busy;
        win_ctl.clr = 1'b1;
      end
      S_RD_OWN: row_req.re = 1'b1;
      S_RD_PAR: begin
        row_req.re   = 1'b1;
        row_req.addr = pidx_q;
      end
      S_SCAN: time_req.re = 1'b1;
      S_WR_PAR: begin
        row_req.we   = 1'b1;
        row_req.addr = pidx_q;
        row_wdata    = par_new;
      end
      S_WR_OWN: begin
        row_req.we    = 1'b1;
        time_req.we   = 1'b1;
        time_req.addr = obase_q + TA_W'(own_row_q.head);
      end
      S_FIN: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
    end else if (state_q == S_WR_OWN && t_q > latest_q) begin
      latest_q <= t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q            <= cmd_i;
      bad_q            <= !addr_ok;
      has_par_q        <= has_par;
      t_q              <= t_in;
      miss_q           <= missed_triggers_i;
      idx_q            <= idx;
      pidx_q           <= pidx;
      obase_q          <= TA_W'(TA_W'(idx) * TA_W'(HISTORY_DEPTH));
      pbase_q          <= TA_W'(TA_W'(pidx) * TA_W'(HISTORY_DEPTH));
      thr_before_q.all <= diff_before[TIME_W];
      thr_before_q.lim <= diff_before[TIME_W-1:0];
      thr_after_q.all  <= diff_after[TIME_W];
      thr_after_q.lim  <= diff_after[TIME_W-1:0];
    end
    // Own row arrives in the cycle after its read
    if (state_q == S_RD_PAR || state_q == S_OWN_DATA) begin
      own_row_q <= row_rdata;
    end
    if (state_q == S_PAR_DATA) begin
      par_row_q <= row_rdata;
      scan_q    <= '0;
    end else if (state_q == S_SCAN) begin
      scan_q <= scan_q + 1'b1;
    end
    // Hold the updated own row for the result
    if (state_q == S_WR_OWN) begin
      own_row_q <= own_new;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      own_out_q   <= bad_q ? '0 : sat_new(own_cnt);
      par_out_q   <= bad_q ? '0 : sat_new(par_cnt);
      hit_out_q   <= bad_q ? '0 : own_row_q.hits;
      coinc_out_q <= bad_q ? '0 : own_row_q.coinc;
      span_out_q  <= latest_q;
      bad_out_q   <= bad_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign new_coinc_own_o     = own_out_q;
  assign new_coinc_partner_o = par_out_q;
  assign hit_total_o         = hit_out_q;
  assign coinc_total_o       = coinc_out_q;
  assign run_span_o          = STAMP_W'(span_out_q);
  assign bad_address_o       = bad_out_q;

  pccc_row_store u_row_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (row_req),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata),
    .busy_o  (row_busy)
  );

  pccc_time_store u_time_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (time_req),
    .wdata_i  (t_q),
    .rdata_o  (time_rdata),
    .rvalid_o (time_rvalid)
  );

  pccc_window_unit u_window_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (win_ctl),
    .time_i       (time_rdata),
    .thr_before_i (thr_before_q),
    .thr_after_i  (thr_after_q),
    .own_cnt_o    (own_cnt),
    .par_cnt_o    (par_cnt)
  );

endmodule
